FILE: hdl/vbfd_pkg.sv
// Package for the vehicle bus frame decoder: codes, word map, helpers.
// No dependencies.
`default_nettype none
package vbfd_pkg;

   localparam int DefValueWords = 64;

   typedef enum logic [1:0] {
      ACT_FRAME = 2'd0,
      ACT_TICK  = 2'd1,
      ACT_READ  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   localparam logic [2:0] SRC_MAIN = 3'd0;
   localparam logic [2:0] SRC_LOCK = 3'd1;
   localparam logic [2:0] SRC_TYRE = 3'd2;
   localparam logic [2:0] SRC_ODO  = 3'd4;

   localparam logic [2:0] NC_CHARGE_STOP = 3'd0;
   localparam logic [2:0] NC_ENV         = 3'd1;
   localparam logic [2:0] NC_VALET       = 3'd2;
   localparam logic [2:0] NC_ALARM       = 3'd3;
   localparam logic [2:0] NC_LOW_CHARGE  = 3'd4;

   localparam logic [1:0] CSR_KM     = 2'd0;
   localparam logic [1:0] CSR_THRESH = 2'd1;
   localparam logic [1:0] CSR_OLDER  = 2'd2;

   // value word indexes
   localparam int W_SOC = 0, W_IDEAL = 1, W_EST = 2, W_TIME = 3, W_AMB = 4;
   localparam int W_LAT = 5, W_LON = 6, W_LOCK = 7, W_DIR = 8, W_ALT = 9;
   localparam int W_CCUR = 10, W_CLIM = 11, W_CDUR = 12, W_SPEED = 13;
   localparam int W_LINEV = 14, W_CSTATE = 15, W_CSUB = 16, W_CMODE = 17;
   localparam int W_CB4 = 18, W_CKWH = 19, W_DOORS = 20, W_PARK = 24;
   localparam int W_TPEM = 25, W_TMOT = 26, W_TBAT = 27, W_LOCKST = 28;
   localparam int W_TYP = 29, W_TYT = 33, W_ODO = 37, W_TRIP = 38;
   localparam int W_TMODE = 39, W_TSTART = 40, W_MODEL = 41, W_SUFFIX = 42;
   localparam int NumStored = 43;

   localparam int S_TIMER = 0, S_AMB = 1, S_GPS = 2, S_TEMPS = 3, S_TPMS = 4;

   typedef struct packed {
      logic [2:0]       count;
      logic [3:0][2:0]  code;
      logic             is_read;
      logic [31:0]      rdata;
   } result_type;

   function automatic logic [31:0] sx8(input logic [7:0] b);
      return {{24{b[7]}}, b};
   endfunction

endpackage
`default_nettype wire

FILE: hdl/vbfd_out_queue.sv
// Result queue: holds up to four results of one request and serializes them.
// Depends on vbfd_pkg.
`default_nettype none
module vbfd_out_queue
   import vbfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        load,
   input  wire result_type  load_data,
   output logic             free,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_result_kind,
   output logic [2:0]       rsp_notify_code,
   output logic [31:0]      rsp_read_value,
   output logic             rsp_last
);
   result_type  res_ff;
   logic [2:0]  pos_ff, pos_in;
   logic        busy_ff, busy_in;
   result_type  res_in;
   logic        done;

   // current result leaves this cycle and it is the final one
   assign done = busy_ff && rsp_ready && (pos_ff + 3'd1 == res_ff.count);
   assign free = !busy_ff || done;

   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      res_in  = res_ff;
      if (busy_ff && rsp_ready) begin
         pos_in = pos_ff + 3'd1;
         if (done) busy_in = 1'b0;
      end
      if (load && free) begin
         res_in  = load_data;
         pos_in  = 3'd0;
         busy_in = (load_data.count != 3'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
      res_ff <= res_in;
   end

   assign rsp_valid       = busy_ff;
   assign rsp_result_kind = res_ff.is_read;
   assign rsp_notify_code = res_ff.is_read ? 3'd0 : res_ff.code[pos_ff[1:0]];
   assign rsp_read_value  = res_ff.is_read ? res_ff.rdata : 32'd0;
   assign rsp_last        = (pos_ff + 3'd1 == res_ff.count);
endmodule
`default_nettype wire

FILE: hdl/vehicle_bus_frame_decoder.sv
// Vehicle bus frame decoder top level: input register, decode, result queue.
// The input register feeds the decode, whose results are registered in the queue.
// One request per cycle when each gives at most one result and rsp_ready is
// high; throughput is set by the result queue draining one result per cycle.
// Synchronous active-high reset clears all value state and config.
// Depends on vbfd_pkg, vbfd_out_queue.
`default_nettype none
module vehicle_bus_frame_decoder
   import vbfd_pkg::*;
#(
   parameter int VALUE_WORDS = DefValueWords
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_action,
   input  wire logic [2:0]  req_frame_source,
   input  wire logic [7:0]  req_byte0,
   input  wire logic [7:0]  req_byte1,
   input  wire logic [7:0]  req_byte2,
   input  wire logic [7:0]  req_byte3,
   input  wire logic [7:0]  req_byte4,
   input  wire logic [7:0]  req_byte5,
   input  wire logic [7:0]  req_byte6,
   input  wire logic [7:0]  req_byte7,
   input  wire logic [5:0]  req_read_index,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [6:0]  csr_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_result_kind,
   output logic [2:0]       rsp_notify_code,
   output logic [31:0]      rsp_read_value,
   output logic             rsp_last
);
   // config
   logic       km_ff, older_ff;
   logic [6:0] thresh_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         km_ff <= 1'b0; thresh_ff <= 7'd0; older_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_KM:     km_ff     <= csr_data[0];
            CSR_THRESH: thresh_ff <= csr_data;
            CSR_OLDER:  older_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // input register
   logic       ivld_ff, ivld_in, free;
   logic [1:0] act_ff;
   logic [2:0] src_ff;
   logic [7:0] b_ff [8];
   logic [5:0] ridx_ff;
   assign req_ready = !ivld_ff || free;
   assign ivld_in   = req_valid ? 1'b1 : (ivld_ff && !free);
   always_ff @(posedge clock) begin
      if (reset) ivld_ff <= 1'b0;
      else       ivld_ff <= ivld_in;
      if (req_valid && req_ready) begin
         act_ff <= req_action; src_ff <= req_frame_source; ridx_ff <= req_read_index;
         b_ff[0] <= req_byte0; b_ff[1] <= req_byte1; b_ff[2] <= req_byte2;
         b_ff[3] <= req_byte3; b_ff[4] <= req_byte4; b_ff[5] <= req_byte5;
         b_ff[6] <= req_byte6; b_ff[7] <= req_byte7;
      end
   end
   logic fire;
   assign fire = ivld_ff && free;

   // state
   logic [31:0] vf_ff [NumStored];
   logic [31:0] vf_in [NumStored];
   logic [7:0]  vin_ff [17];
   logic [7:0]  vin_in [17];
   logic [6:0]  st_ff [5];
   logic [6:0]  st_in [5];
   logic        lca_ff, lca_in, lom_ff, lom_in;
   logic [9:0]  sec_ff, sec_in;
   result_type  res;

   function automatic logic [31:0] rd(input logic [31:0] v, input int i);
      return (i < VALUE_WORDS) ? v : 32'd0;
   endfunction

   logic [31:0] cs, v16a, v16b;
   logic [7:0]  d1;
   logic [36:0] kprod;
   logic [8:0]  kq;
   logic [7:0]  kmh;
   logic [9:0]  sec_inc;
   logic [31:0] soc;
   logic [31:0] rv;

   always_comb begin
      for (int i = 0; i < NumStored; i++) vf_in[i] = vf_ff[i];
      for (int i = 0; i < 17; i++) vin_in[i] = vin_ff[i];
      for (int i = 0; i < 5; i++) st_in[i] = st_ff[i];
      lca_in = lca_ff; lom_in = lom_ff; sec_in = sec_ff;
      res = '0;
      cs = rd(vf_ff[W_CSTATE], W_CSTATE);
      d1 = b_ff[1];
      // km/h = (mph*1609 + 500) / 1000, folded into one reciprocal multiply
      kprod = 37'(b_ff[1]) * 37'd431913524 + 37'd134218000;
      kq    = kprod[36:28];
      kmh   = kq[8] ? 8'd255 : kq[7:0];
      v16a = '0; v16b = '0;
      sec_inc = sec_ff + 10'd1;
      soc = rd(vf_ff[W_SOC], W_SOC);
      rv = '0;
      if (fire) begin
         unique case (action_type'(act_ff))
         ACT_FRAME: begin
            if (src_ff == SRC_MAIN) begin
               unique case (b_ff[0])
               8'h06: begin
                  if (b_ff[1] == 8'h1b) begin
                     vf_in[W_TMODE] = {24'd0, b_ff[4]}; st_in[S_TIMER] = 7'd1;
                  end else if (b_ff[1] == 8'h1a) begin
                     vf_in[W_TSTART] = {16'd0, b_ff[4], b_ff[5]}; st_in[S_TIMER] = 7'd1;
                  end
               end
               8'h80: begin
                  vf_in[W_SOC] = {24'd0, b_ff[1]};
                  v16a = {16'd0, b_ff[3], b_ff[2]};
                  v16b = {16'd0, b_ff[7], b_ff[6]};
                  vf_in[W_IDEAL] = (v16a > 32'd6000) ? 32'd0 : v16a;
                  vf_in[W_EST]   = (v16b > 32'd6000) ? 32'd0 : v16b;
               end
               8'h81: vf_in[W_TIME] = {b_ff[7], b_ff[6], b_ff[5], b_ff[4]};
               8'h82: begin vf_in[W_AMB] = sx8(b_ff[1]); st_in[S_AMB] = 7'd120; end
               8'h83: vf_in[W_LAT] = {b_ff[7], b_ff[6], b_ff[5], b_ff[4]};
               8'h84: vf_in[W_LON] = {b_ff[7], b_ff[6], b_ff[5], b_ff[4]};
               8'h85: begin
                  vf_in[W_LOCK] = {24'd0, b_ff[1]};
                  if (b_ff[1] != 8'd0) begin
                     v16a = {16'd0, b_ff[3], b_ff[2]};
                     vf_in[W_DIR] = (v16a == 32'd360) ? 32'd0 : v16a;
                     vf_in[W_ALT] = (b_ff[5][7:4] != 4'd0) ? 32'd0
                                    : {16'd0, b_ff[5], b_ff[4]};
                     st_in[S_GPS] = 7'd120;
                  end else st_in[S_GPS] = 7'd0;
               end
               8'h88: begin
                  vf_in[W_CCUR] = {24'd0, b_ff[1]};
                  vf_in[W_CLIM] = {24'd0, b_ff[6]};
                  vf_in[W_CDUR] = {16'd0, b_ff[3], b_ff[2]};
               end
               8'h89: begin
                  vf_in[W_SPEED] = {24'd0, km_ff ? kmh : b_ff[1]};
                  vf_in[W_LINEV] = {16'd0, b_ff[3], b_ff[2]};
               end
               8'h95: begin
                  if ({24'd0, b_ff[1]} != cs && (cs <= 32'd2 || cs == 32'h0f)
                      && b_ff[1] != 8'h04) begin
                     res.code[res.count[1:0]] = NC_CHARGE_STOP;
                     res.count = res.count + 3'd1;
                  end
                  if ({24'd0, b_ff[1]} != cs ||
                      {24'd0, b_ff[2]} != rd(vf_ff[W_CSUB], W_CSUB)) begin
                     res.code[res.count[1:0]] = NC_ENV;
                     res.count = res.count + 3'd1;
                  end
                  vf_in[W_CSTATE] = {24'd0, b_ff[1]};
                  vf_in[W_CSUB] = {24'd0, b_ff[2]};
                  vf_in[W_CMODE] = (older_ff || lom_ff) ? {28'd0, b_ff[4][3:0]}
                                                        : {28'd0, b_ff[5][7:4]};
                  vf_in[W_CB4] = {24'd0, b_ff[3]};
                  vf_in[W_CKWH] = {24'd0, b_ff[7]};
               end
               8'h96: begin
                  if (cs == 32'h0f) d1 = b_ff[1] | 8'h10;
                  if (rd(vf_ff[W_DOORS], W_DOORS) != {24'd0, d1} ||
                      rd(vf_ff[W_DOORS+1], W_DOORS+1) != {24'd0, b_ff[2]} ||
                      rd(vf_ff[W_DOORS+2], W_DOORS+2) != {24'd0, b_ff[3]} ||
                      rd(vf_ff[W_DOORS+3], W_DOORS+3) != {24'd0, b_ff[4]}) begin
                     res.code[res.count[1:0]] = NC_ENV;
                     res.count = res.count + 3'd1;
                  end
                  if (!vf_ff[W_DOORS+1][6] && b_ff[2][6] && b_ff[2][4]) begin
                     res.code[res.count[1:0]] = NC_VALET;
                     res.count = res.count + 3'd1;
                  end
                  if (!vf_ff[W_DOORS+3][1] && b_ff[4][1]) begin
                     res.code[res.count[1:0]] = NC_ALARM;
                     res.count = res.count + 3'd1;
                  end
                  vf_in[W_DOORS]   = {24'd0, d1};
                  vf_in[W_DOORS+1] = {24'd0, b_ff[2]};
                  vf_in[W_DOORS+2] = {24'd0, b_ff[3]};
                  vf_in[W_DOORS+3] = {24'd0, b_ff[4]};
                  if (!d1[7] && rd(vf_ff[W_PARK], W_PARK) == 32'd0 &&
                      rd(vf_ff[W_TIME], W_TIME) != 32'd0) begin
                     vf_in[W_PARK] = vf_ff[W_TIME] - 32'd1;
                     res.code[res.count[1:0]] = NC_ENV;
                     res.count = res.count + 3'd1;
                  end else if (d1[7] && rd(vf_ff[W_PARK], W_PARK) != 32'd0) begin
                     vf_in[W_PARK] = 32'd0;
                     res.code[res.count[1:0]] = NC_ENV;
                     res.count = res.count + 3'd1;
                  end
               end
               8'hA3: begin
                  vf_in[W_TPEM] = sx8(b_ff[1]);
                  vf_in[W_TMOT] = {24'd0, b_ff[2]};
                  vf_in[W_TBAT] = sx8(b_ff[6]);
                  st_in[S_TEMPS] = 7'd120;
               end
               8'hA4: for (int i = 0; i < 7; i++) vin_in[i] = b_ff[i+1];
               8'hA5: begin
                  for (int i = 0; i < 7; i++) vin_in[i+7] = b_ff[i+1];
                  vf_in[W_MODEL] = (b_ff[3] == 8'h41 || b_ff[3] == 8'h42) ? 32'h32
                                                                         : 32'h31;
                  if (b_ff[3] == 8'h38) lom_in = 1'b1;
                  vf_in[W_SUFFIX] = (b_ff[1] == 8'h33) ? 32'h53 : 32'h4e;
               end
               8'hA6: begin
                  vin_in[14] = b_ff[1]; vin_in[15] = b_ff[2]; vin_in[16] = b_ff[3];
               end
               default: ;
               endcase
            end else if (src_ff == SRC_LOCK) begin
               if (b_ff[0] == 8'h0E) begin
                  if (rd(vf_ff[W_LOCKST], W_LOCKST) != {24'd0, b_ff[1]}) begin
                     res.code[0] = NC_ENV; res.count = 3'd1;
                  end
                  vf_in[W_LOCKST] = {24'd0, b_ff[1]};
               end
            end else if (src_ff == SRC_TYRE) begin
               // wheel order FR, RR, FL, RL at byte pairs 3, 7, 1, 5
               if (b_ff[3] != 0) begin
                  vf_in[W_TYP]   = {24'd0, b_ff[2]}; vf_in[W_TYT]   = sx8(b_ff[3]);
               end
               if (b_ff[7] != 0) begin
                  vf_in[W_TYP+1] = {24'd0, b_ff[6]}; vf_in[W_TYT+1] = sx8(b_ff[7]);
               end
               if (b_ff[1] != 0) begin
                  vf_in[W_TYP+2] = {24'd0, b_ff[0]}; vf_in[W_TYT+2] = sx8(b_ff[1]);
               end
               if (b_ff[5] != 0) begin
                  vf_in[W_TYP+3] = {24'd0, b_ff[4]}; vf_in[W_TYT+3] = sx8(b_ff[5]);
               end
               st_in[S_TPMS] = 7'd120;
            end else if (src_ff == SRC_ODO) begin
               if (b_ff[0] == 8'hFA) begin
                  vf_in[W_ODO]  = {8'd0, b_ff[5], b_ff[4], b_ff[3]};
                  vf_in[W_TRIP] = {16'd0, b_ff[7], b_ff[6]};
               end
            end
         end
         ACT_TICK: begin
            for (int i = S_AMB; i <= S_TPMS; i++)
               if (st_ff[i] != 7'd0) st_in[i] = st_ff[i] - 7'd1;
            sec_in = (sec_inc == 10'd600) ? 10'd0 : sec_inc;
            if (sec_inc == 10'd60 || sec_inc == 10'd120 || sec_inc == 10'd180 ||
                sec_inc == 10'd240 || sec_inc == 10'd300 || sec_inc == 10'd360 ||
                sec_inc == 10'd420 || sec_inc == 10'd480 || sec_inc == 10'd540 ||
                sec_inc == 10'd600) begin
               if (!lca_ff && soc < {25'd0, thresh_ff}) begin
                  res.code[0] = NC_LOW_CHARGE; res.count = 3'd1; lca_in = 1'b1;
               end else if (lca_ff && soc > {25'd0, thresh_ff} + 32'd2) begin
                  lca_in = 1'b0;
               end
            end
         end
         ACT_READ: begin
            if (ridx_ff < 6'd43) rv = rd(vf_ff[ridx_ff], int'(ridx_ff));
            else if (ridx_ff < 6'd48) rv = {25'd0, st_ff[3'(ridx_ff - 6'd43)]};
            else if (ridx_ff < 6'd52) begin
               for (int k = 0; k < 4; k++)
                  rv[8*k +: 8] = vin_ff[5'((ridx_ff - 6'd48) * 4 + k)];
            end else if (ridx_ff == 6'd52) rv = {24'd0, vin_ff[16]};
            else if (ridx_ff == 6'd53) rv = {30'd0, lca_ff, lom_ff};
            else if (ridx_ff == 6'd54) rv = {22'd0, sec_ff};
            res.is_read = 1'b1; res.rdata = rv; res.count = 3'd1;
         end
         ACT_NONE: ;
         default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumStored; i++) vf_ff[i] <= '0;
         for (int i = 0; i < 17; i++) vin_ff[i] <= '0;
         for (int i = 0; i < 5; i++) st_ff[i] <= '0;
         lca_ff <= 1'b0; lom_ff <= 1'b0; sec_ff <= '0;
      end else begin
         for (int i = 0; i < NumStored; i++) vf_ff[i] <= vf_in[i];
         for (int i = 0; i < 17; i++) vin_ff[i] <= vin_in[i];
         for (int i = 0; i < 5; i++) st_ff[i] <= st_in[i];
         lca_ff <= lca_in; lom_ff <= lom_in; sec_ff <= sec_in;
      end
   end

   vbfd_out_queue u_queue (
      .clock, .reset, .load(fire), .load_data(res), .free,
      .rsp_valid, .rsp_ready, .rsp_result_kind, .rsp_notify_code,
      .rsp_read_value, .rsp_last
   );
endmodule
`default_nettype wire
